>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the block.
// Expects clk_i and rst_ni to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed in reset");

`endif

>>> rtl/core/swm_pkg.sv
// Shared types and constants of the sliding window maximum unit.
// No dependencies.
package swm_pkg;

  localparam int unsigned SAMPLE_W         = 16;
  localparam int unsigned CFG_W            = 5;
  localparam int unsigned DEFAULT_MAX_WIN  = 16;
  localparam logic [CFG_W-1:0] WINDOW_RST  = 5'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] hit_count;
    logic                end_of_sequence;
  } swm_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] window_max;
    logic                final_window;
  } swm_out_t;

endpackage

>>> rtl/core/swm_cell.sv
// One cell of the window chain: holds the maximum of the newest samples up to its depth.
// Depends on swm_pkg.
module swm_cell import swm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                clear_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SAMPLE_W-1:0] prev_max_i,
  output logic [SAMPLE_W-1:0] next_max_o,
  output logic [SAMPLE_W-1:0] max_o
);

  logic [SAMPLE_W-1:0] max_q;
  logic [SAMPLE_W-1:0] max_d;

  assign next_max_o = (sample_i > prev_max_i) ? sample_i : prev_max_i;

  always_comb begin
    max_d = max_q;
    if (shift_i) begin
      max_d = clear_i ? '0 : next_max_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else begin
      max_q <= max_d;
    end
  end

  assign max_o = max_q;

endmodule

>>> rtl/core/sliding_window_max_unit.sv
// Sliding window maximum unit: accepts one hit count per cycle; once the
// current sequence holds at least the configured window length of samples,
// every sample yields the maximum of the newest window-length of them from an
// output register loaded at acceptance. The input stalls only while that
// register holds a result that the output side stalls. Each cell k of the
// chain keeps the maximum of the newest k+1 samples and takes its neighbor's
// value and the new sample in the same cycle, so one compare per cell plus the
// window-select mux sets the cycle. A sample carrying end_of_sequence clears the
// chain afterwards. A window length above MAX_WINDOW acts as MAX_WINDOW; a
// window length of 0 gives no result.
// Depends on swm_pkg and swm_cell.
module sliding_window_max_unit import swm_pkg::*; #(
  parameter int unsigned MAX_WINDOW = DEFAULT_MAX_WIN
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  swm_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output swm_out_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CMP_W = (WIN_W > CFG_W) ? WIN_W : CFG_W;

  logic [CFG_W-1:0]    win_len_q;
  logic [WIN_W-1:0]    fill_q, fill_d;
  logic                out_valid_q, out_valid_d;
  swm_out_t            out_data_q, out_data_d;

  logic                accept;
  logic                last;
  logic [SAMPLE_W-1:0] sample;
  logic [CMP_W-1:0]    ws_ext;
  logic [WIN_W-1:0]    win;
  logic [WIN_W-1:0]    fill_next;
  logic [IDX_W-1:0]    sel;
  logic                produce;

  logic [SAMPLE_W-1:0] prev_max [MAX_WINDOW];
  logic [SAMPLE_W-1:0] next_max [MAX_WINDOW];
  logic [SAMPLE_W-1:0] cell_max [MAX_WINDOW];

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign sample      = in_data_i.hit_count;
  assign last        = in_data_i.end_of_sequence;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WINDOW_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      win_len_q <= cfg_data_i;
    end
  end

  assign ws_ext = CMP_W'(win_len_q);
  assign win    = (ws_ext > CMP_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : WIN_W'(ws_ext);

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign prev_max[k] = '0;
    end else begin : g_link
      assign prev_max[k] = cell_max[k-1];
    end
    swm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .clear_i    (last),
      .sample_i   (sample),
      .prev_max_i (prev_max[k]),
      .next_max_o (next_max[k]),
      .max_o      (cell_max[k])
    );
  end

  assign fill_next = (fill_q == WIN_W'(MAX_WINDOW)) ? fill_q : fill_q + WIN_W'(1);
  assign sel       = IDX_W'(win - WIN_W'(1));
  assign produce   = (win != '0) && (fill_next >= win);

  always_comb begin
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (accept) begin
      fill_d                  = last ? '0 : fill_next;
      out_valid_d             = produce;
      out_data_d.window_max   = next_max[sel];
      out_data_d.final_window = last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/core/swm_checker.sv
// Port-level checks of the sliding window maximum unit, bound to the top level.
// Depends on swm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swm_checker import swm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input swm_out_t out_data_o
);

  `ASSERT_PROP(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `ASSERT_PROP(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o))
  `ASSERT_PROP(a_stall_only_on_full, in_stall_o |-> out_valid_o && out_stall_i)
  `ASSERT_PROP(a_result_needs_transaction,
               out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
  `ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |-> !out_valid_o)

endmodule

bind sliding_window_max_unit swm_checker u_swm_checker (.*);
